FILE: design/mewsf_pkg.sv
// Shared widths, constants, codes and types for the encoder unwrap and speed filter.
package mewsf_pkg;

  localparam int SEL_W     = 3;
  localparam int IDX_W     = 2;
  localparam int ANGLE_W   = 13;
  localparam int DELTA_W   = 14;
  localparam int TURN_W    = 19;
  localparam int POS_W     = 32;
  localparam int SPEED_W   = 16;
  localparam int SCALE_W   = 16;
  localparam int WFRM_W    = 16;
  localparam int AVG_W     = 13;   // |ring sum / depth| never exceeds a half turn
  localparam int Q_FRAC    = 10;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  localparam int HalfTurn = 4096;
  localparam int FullTurn = 8192;

  localparam logic [WFRM_W-1:0]  WARMUP_RST = 16'd1000;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd7500;

  localparam int AVG_DEPTH_DEF   = 8;
  localparam int MOTOR_COUNT_DEF = 4;

  // configuration register indexes
  localparam logic CFG_WARMUP = 1'b0;
  localparam logic CFG_SCALE  = 1'b1;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] speed;
  } spd_rsp_t;

endpackage

FILE: design/motor_encoder_unwrap_speed_filter.sv
// Top level: frame control, per-motor state and delta ring memories, result register.
//
//  channel   dir  handshake             payload
//  in_       in   in_tvalid/in_tready   tuser: motor_select, tdata: raw_angle
//  out_      out  out_tvalid/out_tready tuser: motor_index, in_warmup;
//                                       tdata: angle_delta, position, speed
//  cfg_      in   cfg_we                cfg_index, cfg_wdata
//
//  A motor frame goes from acceptance to the result register through one state memory
//  read, one ring memory read with the state update, and the speed pipeline.
//  The next frame is taken the cycle after the result loads.
//  Other frames only update the warm-up counter.
//  Reset is synchronous; per-motor valid bits and a ring-full flag stand in for
//  clearing the memories, so no clearing pass is needed.
//  A held result stalls the block only when the next result is ready to load.
module motor_encoder_unwrap_speed_filter import mewsf_pkg::*; #(
  parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SEL_W-1:0]      in_tuser,   // [2:0] motor_select
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [12:0] raw_angle, rest zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_USER_W-1:0] out_tuser,  // [1:0] motor_index, [2] in_warmup
  output logic [OUT_DATA_W-1:0] out_tdata,  // [13:0] angle_delta, [45:14] position,
                                            // [61:46] speed, rest zero
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [WFRM_W-1:0]     cfg_wdata
);

  localparam int MA_W    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int PTR_W   = $clog2(AVG_DEPTH);
  localparam int SUM_W   = DELTA_W + PTR_W;
  localparam int RDEPTH  = MOTOR_COUNT * AVG_DEPTH;
  localparam int RA_W    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  // state word layout, lowest bits first
  localparam int LA_LO   = 0;
  localparam int OFF_LO  = LA_LO + ANGLE_W;
  localparam int TRN_LO  = OFF_LO + ANGLE_W;
  localparam int DL_LO   = TRN_LO + TURN_W;
  localparam int PTR_LO  = DL_LO + DELTA_W;
  localparam int FULL_LO = PTR_LO + PTR_W;
  localparam int SUM_LO  = FULL_LO + 1;
  localparam int ST_W    = SUM_LO + SUM_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_RDST, ST_UPD, ST_SPD, ST_EMIT} state_t;

  state_t state_r, state_nxt;

  logic [WFRM_W-1:0]  wfrm_r, wcnt_r, wcnt_nxt, wcnt_inc;
  logic [SCALE_W-1:0] scale_r;
  logic [MOTOR_COUNT-1:0] mvalid_r;

  logic [SEL_W-1:0]   sel_r;
  logic [ANGLE_W-1:0] angle_r;
  logic               warm_r, warm_nxt;

  logic [ANGLE_W-1:0] la_r, off_r;
  logic [TURN_W-1:0]  turn_r;
  logic [DELTA_W-1:0] dl_r;
  logic [PTR_W-1:0]   ptr_r;
  logic               full_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RA_W-1:0]    raddr_r;

  logic [DELTA_W-1:0] pend_dl_r;
  logic [POS_W-1:0]   pend_pos_r;

  logic               out_vld_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_warm_r;
  logic [DELTA_W-1:0] out_dl_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [SPEED_W-1:0] out_spd_r;

  logic               in_acc, in_hit, out_free, out_load;
  logic [MA_W-1:0]    st_raddr, cur_idx;
  logic [ST_W-1:0]    st_rdata, st_wdata, st_dec;
  logic [DELTA_W-1:0] ring_rdata, ring_old;
  logic [RA_W-1:0]    ring_raddr;
  logic               st_we;

  logic signed [DELTA_W:0]   d15;
  logic [ANGLE_W-1:0] la_n, off_n;
  logic [TURN_W-1:0]  turn_n;
  logic [DELTA_W-1:0] dl_n, diff_n;
  logic [PTR_W-1:0]   ptr_n;
  logic               full_n;
  logic [SUM_W-1:0]   sum_n;
  logic [POS_W-1:0]   pos_n;
  spd_rsp_t           spd_rsp;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_hit    = ({1'b0, in_tuser} < 4'(MOTOR_COUNT));
  assign cur_idx   = sel_r[MA_W-1:0];
  assign st_raddr  = (state_r == ST_IDLE) ? in_tuser[MA_W-1:0] : cur_idx;
  assign out_free  = !out_vld_r || out_tready;
  assign st_we     = (state_r == ST_UPD);

  // warm-up counter: advance, clamp to the limit
  always_comb begin
    wcnt_inc = (wcnt_r < wfrm_r) ? wcnt_r + WFRM_W'(1) : wcnt_r;
    wcnt_nxt = (wcnt_inc >= wfrm_r) ? wfrm_r : wcnt_inc;
    warm_nxt = (wcnt_nxt < wfrm_r);
  end

  // a motor never written reads as all zero
  assign st_dec   = mvalid_r[cur_idx] ? st_rdata : '0;
  assign ring_raddr = RA_W'(cur_idx) * RA_W'(AVG_DEPTH) + RA_W'(st_dec[PTR_LO +: PTR_W]);
  // ring slots are only written in pointer order, so before the first wrap they read zero
  assign ring_old = full_r ? ring_rdata : '0;

  always_comb begin
    d15    = signed'({2'b00, angle_r}) - signed'({2'b00, la_r});
    la_n   = angle_r;
    off_n  = off_r;
    turn_n = turn_r;
    dl_n   = dl_r;
    if (warm_r) begin
      off_n = angle_r;
    end else if (d15 > (DELTA_W + 1)'(HalfTurn)) begin
      turn_n = turn_r - TURN_W'(1);
      dl_n   = DELTA_W'(d15 - (DELTA_W + 1)'(FullTurn));
    end else if (d15 < -(DELTA_W + 1)'(HalfTurn)) begin
      turn_n = turn_r + TURN_W'(1);
      dl_n   = DELTA_W'(d15 + (DELTA_W + 1)'(FullTurn));
    end else begin
      dl_n   = DELTA_W'(d15);
    end
    sum_n  = sum_r - SUM_W'(signed'(ring_old)) + SUM_W'(signed'(dl_n));
    ptr_n  = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
    full_n = full_r || (ptr_r == PTR_LAST);
    diff_n = {1'b0, la_n} - {1'b0, off_n};
    pos_n  = {turn_n, {ANGLE_W{1'b0}}} + POS_W'(signed'(diff_n));
    st_wdata = {sum_n, full_n, ptr_n, dl_n, turn_n, off_n, la_n};
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_hit) begin
          state_nxt = ST_RDST;
        end
      end
      ST_RDST: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_SPD;
      ST_SPD: begin
        if (spd_rsp.done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wfrm_r    <= WARMUP_RST;
      scale_r   <= SCALE_RST;
      wcnt_r    <= '0;
      mvalid_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WARMUP: wfrm_r  <= cfg_wdata;
          CFG_SCALE:  scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        wcnt_r <= wcnt_nxt;
      end
      if (st_we) begin
        mvalid_r[cur_idx] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_acc) begin
      sel_r   <= in_tuser;
      angle_r <= in_tdata[ANGLE_W-1:0];
      warm_r  <= warm_nxt;
    end
    if (state_r == ST_RDST) begin
      la_r    <= st_dec[LA_LO +: ANGLE_W];
      off_r   <= st_dec[OFF_LO +: ANGLE_W];
      turn_r  <= st_dec[TRN_LO +: TURN_W];
      dl_r    <= st_dec[DL_LO +: DELTA_W];
      ptr_r   <= st_dec[PTR_LO +: PTR_W];
      full_r  <= st_dec[FULL_LO];
      sum_r   <= st_dec[SUM_LO +: SUM_W];
      raddr_r <= ring_raddr;
    end
    if (st_we) begin
      pend_dl_r  <= dl_n;
      pend_pos_r <= pos_n;
    end
    if (out_load) begin
      out_idx_r  <= sel_r[IDX_W-1:0];
      out_warm_r <= warm_r;
      out_dl_r   <= pend_dl_r;
      out_pos_r  <= pend_pos_r;
      out_spd_r  <= spd_rsp.speed;
    end
  end

  mewsf_ram #(
    .WIDTH (ST_W),
    .DEPTH (MOTOR_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (cur_idx),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mewsf_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (RDEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (raddr_r),
    .wdata (dl_n),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  mewsf_speed #(
    .AVG_DEPTH (AVG_DEPTH),
    .SUM_W     (SUM_W)
  ) u_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_we),
    .sum   (signed'(sum_n)),
    .scale (scale_r),
    .rsp   (spd_rsp)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {out_warm_r, out_idx_r};
  assign out_tdata  = {2'b00, out_spd_r, out_pos_r, out_dl_r};

  a_wcnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (wcnt_r <= $past(wfrm_r)))
    else $error("warm-up counter above its limit");

  a_spd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    spd_rsp.done |-> (state_r == ST_SPD))
    else $error("speed result outside its wait state");

  a_other_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_hit) |=> (state_r == ST_IDLE))
    else $error("non-motor frame started a memory access");

  a_out_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_SPD || $past(state_r) == ST_EMIT))
    else $error("result loaded without a finished item");

endmodule

FILE: design/mewsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mewsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mewsf_speed.sv
// Speed pipeline: ring sum divided by the averaging depth, scaled by Q10 gain, saturated.
module mewsf_speed import mewsf_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF,
  parameter int SUM_W     = DELTA_W + $clog2(AVG_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic [SCALE_W-1:0]        scale,
  output spd_rsp_t                  rsp
);

  localparam logic [SUM_W-1:0] RECIP   = SUM_W'((2 ** SUM_W) / AVG_DEPTH);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(AVG_DEPTH);
  localparam int PM_W = AVG_W + SCALE_W;
  localparam int SH_W = PM_W - Q_FRAC;

  logic [4:0]           vld_r;
  logic [SUM_W-1:0]     mag_r, mag1_r, qe_r;
  logic [AVG_W-1:0]     q_r;
  logic [PM_W-1:0]      pm_r;
  logic [3:0]           neg_r;
  logic [SPEED_W-1:0]   speed_r;

  logic [SUM_W-1:0]     mag_nxt;
  logic [2*SUM_W-1:0]   pf;
  logic [SUM_W-1:0]     qd, rem, q_nxt;
  logic [PM_W-1:0]      pm_nxt;
  logic [SH_W-1:0]      shifted;
  logic [SPEED_W-1:0]   speed_nxt;

  always_comb begin
    mag_nxt = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    pf      = {{SUM_W{1'b0}}, mag_r} * {{SUM_W{1'b0}}, RECIP};
    // reciprocal estimate is low by at most one
    qd      = qe_r * DIVISOR;
    rem     = mag1_r - qd;
    q_nxt   = (rem >= DIVISOR) ? qe_r + SUM_W'(1) : qe_r;
    pm_nxt  = {{SCALE_W{1'b0}}, q_r} * {{AVG_W{1'b0}}, scale};
    shifted = pm_r[PM_W-1:Q_FRAC];
    if (!neg_r[3]) begin
      speed_nxt = (shifted > SH_W'(32767)) ? 16'h7fff : shifted[SPEED_W-1:0];
    end else begin
      speed_nxt = (shifted > SH_W'(32768)) ? 16'h8000 : SPEED_W'(-shifted[SPEED_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
    mag_r  <= mag_nxt;
    qe_r   <= pf[2*SUM_W-1:SUM_W];
    mag1_r <= mag_r;
    q_r    <= q_nxt[AVG_W-1:0];
    pm_r   <= pm_nxt;
    neg_r  <= {neg_r[2:0], sum[SUM_W-1]};
    if (vld_r[3]) begin
      speed_r <= speed_nxt;
    end
  end

  assign rsp.done  = vld_r[4];
  assign rsp.speed = speed_r;

endmodule

FILE: tb/testbench.sv
// Testbench for the encoder unwrap and speed filter: random frames checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import mewsf_pkg::*;

  localparam int MOTORS      = MOTOR_COUNT_DEF;
  localparam int DEPTH       = AVG_DEPTH_DEF;
  localparam int PAD_CYCLES  = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_CAP   = 40;
  localparam logic [SEL_W-1:0] OTHER_FRAME = SEL_W'(MOTOR_COUNT_DEF);

  typedef struct packed {
    logic [SEL_W-1:0]   sel;
    logic [ANGLE_W-1:0] angle;
  } frame_t;

  typedef struct packed {
    logic [IDX_W-1:0]   motor_index;
    logic               in_warmup;
    logic [DELTA_W-1:0] angle_delta;
    logic [POS_W-1:0]   position;
    logic [SPEED_W-1:0] speed;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SEL_W-1:0]      in_tuser = '0;   // [2:0] motor_select
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [12:0] raw_angle, rest zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_USER_W-1:0] out_tuser;       // [1:0] motor_index, [2] in_warmup
  logic [OUT_DATA_W-1:0] out_tdata;       // [13:0] angle_delta, [45:14] position,
                                          // [61:46] speed, rest zero
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_WARMUP;
  logic [WFRM_W-1:0]     cfg_wdata = '0;

  motor_encoder_unwrap_speed_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [WFRM_W-1:0]         warm_limit = WARMUP_RST;
  logic [SCALE_W-1:0]        gain = SCALE_RST;
  logic [WFRM_W-1:0]         warm_count = '0;
  logic [ANGLE_W-1:0]        last_ang [MOTORS] = '{default: '0};
  logic [ANGLE_W-1:0]        offset_ang [MOTORS] = '{default: '0};
  logic [TURN_W-1:0]         turns [MOTORS] = '{default: '0};
  logic signed [DELTA_W-1:0] prev_delta [MOTORS] = '{default: '0};
  logic signed [DELTA_W-1:0] delta_hist [MOTORS][DEPTH] = '{default: '{default: '0}};
  int                        hist_at [MOTORS] = '{default: 0};

  frame_t   frames_to_send [$];
  reading_t readings_due [$];
  int       frames_queued = 0;
  int       frames_accepted = 0;
  int       errors = 0;
  int       quiet = 0;
  int       in_gap = 0;
  int       out_hold = 0;
  bit       in_taken = 1'b0;
  bit       out_taken = 1'b0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;
  logic [ANGLE_W-1:0] walk [MOTORS] = '{default: '0};
  int       drift [MOTORS];

  function automatic logic predict_reading(input logic [SEL_W-1:0] sel,
                                           input logic [ANGLE_W-1:0] angle,
                                           output reading_t r);
    int     m, d, sum;
    longint avg, prod, spd;
    logic   warm;
    logic [POS_W-1:0] pos;
    r = '0;
    if (warm_count < warm_limit) warm_count++;
    if (warm_count >= warm_limit) warm_count = warm_limit;
    warm = warm_count < warm_limit;
    if (sel >= MOTORS) return 1'b0;
    m = int'(sel);
    if (warm) begin
      last_ang[m] = angle;
      offset_ang[m] = angle;
    end else begin
      d = int'(angle) - int'(last_ang[m]);
      if (d > HalfTurn) begin
        turns[m] = turns[m] - 1'b1;
        d -= FullTurn;
      end else if (d < -HalfTurn) begin
        turns[m] = turns[m] + 1'b1;
        d += FullTurn;
      end
      prev_delta[m] = DELTA_W'(d);
      last_ang[m] = angle;
    end
    // during warm-up the old delta goes into the ring again
    delta_hist[m][hist_at[m]] = prev_delta[m];
    hist_at[m] = (hist_at[m] == DEPTH - 1) ? 0 : hist_at[m] + 1;
    sum = 0;
    for (int i = 0; i < DEPTH; i++) sum += int'(delta_hist[m][i]);
    avg = longint'(sum / DEPTH);
    prod = avg * longint'(gain);
    spd = prod / 1024;
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;
    pos = {turns[m], {ANGLE_W{1'b0}}} + POS_W'(last_ang[m]) - POS_W'(offset_ang[m]);
    r.motor_index = sel[IDX_W-1:0];
    r.in_warmup = warm;
    r.angle_delta = prev_delta[m];
    r.position = pos;
    r.speed = SPEED_W'(spd);
    return 1'b1;
  endfunction

  function automatic int idle_cycles(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string fname, input logic [POS_W-1:0] got_v,
                             input logic [POS_W-1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %h want %h", fname, got_v, want_v));
  endtask

  // frame source
  always @(negedge clk) begin : source
    frame_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // item still waiting for in_tready
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (frames_to_send.size() > 0) begin
      nxt = frames_to_send.pop_front();
      in_tuser <= nxt.sel;
      in_tdata <= IN_DATA_W'(nxt.angle);
      in_tvalid <= 1'b1;
      in_gap <= idle_cycles(in_calm);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result sink: a fresh stall is drawn after every accepted item
  always @(negedge clk) begin : sink
    int wait_n;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      wait_n = out_taken ? idle_cycles(out_calm) : out_hold;
      out_tready <= (wait_n == 0);
      out_hold <= (wait_n == 0) ? 0 : wait_n - 1;
    end
  end

  always @(posedge clk) begin : monitor
    reading_t want, got;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        got.motor_index = out_tuser[IDX_W-1:0];
        got.in_warmup = out_tuser[IDX_W];
        got.angle_delta = out_tdata[DELTA_W-1:0];
        got.position = out_tdata[DELTA_W +: POS_W];
        got.speed = out_tdata[DELTA_W+POS_W +: SPEED_W];
        if (readings_due.size() == 0) begin
          report_mismatch("result with no frame waiting");
        end else begin
          want = readings_due.pop_front();
          check_field("motor_index", POS_W'(got.motor_index), POS_W'(want.motor_index));
          check_field("in_warmup", POS_W'(got.in_warmup), POS_W'(want.in_warmup));
          check_field("angle_delta", POS_W'(got.angle_delta), POS_W'(want.angle_delta));
          check_field("position", got.position, want.position);
          check_field("speed", POS_W'(got.speed), POS_W'(want.speed));
        end
      end
      if (in_tvalid && in_tready) begin
        frames_accepted <= frames_accepted + 1;
        if (predict_reading(in_tuser, in_tdata[ANGLE_W-1:0], want))
          readings_due.push_back(want);
      end
      quiet <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_frame(input logic [SEL_W-1:0] sel, input logic [ANGLE_W-1:0] angle);
    frame_t f;
    f.sel = sel;
    f.angle = angle;
    frames_to_send.push_back(f);
    frames_queued++;
    if (sel < MOTORS) walk[sel] = angle;
  endtask

  task automatic queue_step(input int m, input int step);
    queue_frame(SEL_W'(m), ANGLE_W'(int'(walk[m]) + step));
  endtask

  // block must be idle before a register write
  task automatic settle();
    while (frames_accepted != frames_queued || readings_due.size() != 0) @(posedge clk);
    repeat (PAD_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [WFRM_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_WARMUP) warm_limit = value;
    else gain = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int items, pick, m, sgn;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: every frame is a warm-up frame
    queue_frame(SEL_W'(0), 13'd0);
    queue_frame(SEL_W'(1), 13'd8191);
    queue_frame(SEL_W'(2), 13'd4096);
    queue_frame(SEL_W'(3), 13'd1234);
    queue_frame(OTHER_FRAME, 13'd8191);
    queue_frame(OTHER_FRAME, 13'd0);
    settle();

    // limit below the counter: clamped on the next frame
    write_reg(CFG_WARMUP, 16'd2);
    write_reg(CFG_SCALE, 16'hFFFF);
    queue_frame(SEL_W'(0), 13'd4096);   // exactly a half turn, no wrap
    queue_frame(SEL_W'(0), 13'd8191);
    queue_frame(SEL_W'(0), 13'd0);      // forward wrap
    queue_frame(SEL_W'(1), 13'd4094);   // back by more than a half turn
    queue_frame(SEL_W'(1), 13'd8191);
    queue_frame(SEL_W'(2), 13'd0);      // back by exactly a half turn
    queue_step(2, -4000);               // negative speed saturation
    for (int k = 0; k < DEPTH; k++) queue_step(3, 4000);  // positive saturation
    queue_frame(OTHER_FRAME, 13'd4660);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_WARMUP, 16'd1);     write_reg(CFG_SCALE, 16'd0);    end
        1: begin write_reg(CFG_WARMUP, 16'd0);     write_reg(CFG_SCALE, 16'd1024); end
        2: begin write_reg(CFG_WARMUP, 16'hFFFF);  write_reg(CFG_SCALE, 16'd7500); end
        3: begin write_reg(CFG_WARMUP, 16'd1);     write_reg(CFG_SCALE, 16'hFFFF); end
        4: begin
          write_reg(CFG_WARMUP, WFRM_W'($urandom_range(20, 60)));
          write_reg(CFG_SCALE, SCALE_W'($urandom_range(0, 65535)));
        end
        5: begin
          write_reg(CFG_WARMUP, WFRM_W'($urandom_range(61, 120)));
          write_reg(CFG_SCALE, SCALE_W'($urandom_range(6000, 9000)));
        end
        6: begin
          write_reg(CFG_WARMUP, 16'd1);
          write_reg(CFG_SCALE, SCALE_W'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(CFG_WARMUP, WFRM_W'($urandom_range(121, 200)));
          write_reg(CFG_SCALE, SCALE_W'(7500));
        end
      endcase
      for (int k = 0; k < MOTORS; k++) drift[k] = int'($urandom_range(0, 8000)) - 4000;
      items = (ph == 2) ? 40 : 150;
      for (int n = 0; n < items; n++) begin
        pick = int'($urandom_range(0, 99));
        m = int'($urandom_range(0, MOTORS - 1));
        sgn = $urandom_range(0, 1) ? 1 : -1;
        if (pick < 10)
          queue_frame(OTHER_FRAME, ANGLE_W'($urandom_range(0, 8191)));
        else if (pick < 60)
          queue_step(m, drift[m] + int'($urandom_range(0, 300)) - 150);
        else if (pick < 80)
          queue_step(m, int'($urandom_range(0, 4000)) - 2000);
        else if (pick < 92)
          queue_step(m, sgn * int'($urandom_range(4090, 4102)));   // around a half turn
        else
          queue_frame(SEL_W'(m), ANGLE_W'($urandom_range(0, 8191)));
      end
      settle();
    end

    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
design/mewsf_pkg.sv
design/mewsf_ram.sv
design/mewsf_speed.sv
design/motor_encoder_unwrap_speed_filter.sv
tb/testbench.sv
